// ===== design/vrsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrsc_pkg
// Shared types and codes for the voice route session controller.
// ----------------------------------------------------------------------------
package vrsc_pkg;

  localparam int DELAY_W = 32;
  localparam int CMD_W = 3;
  localparam int HEADS_W = 8;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    LIFE_OFF    = 2'd0,
    LIFE_ACTIVE = 2'd1,
    LIFE_SLEEP  = 2'd2
  } life_t;

  typedef enum logic [1:0] {
    ROUTE_RELAY = 2'd0,
    ROUTE_PROBE = 2'd1,
    ROUTE_PEER  = 2'd2
  } route_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_CONNECT    = 3'd0,
    CMD_DISCONNECT = 3'd1,
    CMD_COUNT      = 3'd2,
    CMD_TICK       = 3'd3,
    CMD_PROBE_OK   = 3'd4,
    CMD_PROBE_FAIL = 3'd5,
    CMD_APPLY      = 3'd6
  } cmd_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PEER_ENABLE    = 3'd0,
    CFG_SERVER_DENOISE = 3'd1,
    CFG_SOLO_SLEEP     = 3'd2,
    CFG_PEER_STABLE    = 3'd3,
    CFG_PROBE_LIMIT    = 3'd4
  } cfg_index_t;

  localparam logic [DELAY_W-1:0] SOLO_SLEEP_RST  = 32'd30000;
  localparam logic [DELAY_W-1:0] PEER_STABLE_RST = 32'd2000;
  localparam logic [DELAY_W-1:0] PROBE_LIMIT_RST = 32'd5000;

  typedef struct packed {
    logic               peer_enable;
    logic               server_denoise;
    logic [DELAY_W-1:0] solo_sleep_delay;
    logic [DELAY_W-1:0] peer_stable_delay;
    logic [DELAY_W-1:0] probe_time_limit;
  } cfg_t;

  typedef struct packed {
    life_t  life;
    route_t route;
    logic   wake;
    logic   cancel;
    logic   rel_media;
    logic   start_probe;
  } result_t;

endpackage

// ===== design/vrsc_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrsc_engine
// Session state registers and the per-event next-state logic. The result for
// the presented event is combinational; state moves when step is high.
// ----------------------------------------------------------------------------
module vrsc_engine #(
  parameter int MAX_PARTICIPANTS = 255,
  parameter int TIME_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [vrsc_pkg::CMD_W-1:0]    cmd,
  input  logic [TIME_BITS-1:0]          now_time,
  input  logic [vrsc_pkg::HEADS_W-1:0]  head_count,
  input  vrsc_pkg::cfg_t                cfg,
  output vrsc_pkg::result_t             res
);
  import vrsc_pkg::*;

  localparam int CW = $clog2(MAX_PARTICIPANTS + 1);
  localparam int SW = (CW > HEADS_W) ? CW : HEADS_W;
  localparam int CMPW = (TIME_BITS > DELAY_W) ? TIME_BITS : DELAY_W;

  life_t                life, life_next;
  route_t               route, route_next;
  logic [CW-1:0]        count, count_next;
  logic [TIME_BITS-1:0] occ_stamp, occ_stamp_next;
  logic [TIME_BITS-1:0] probe_stamp, probe_stamp_next;
  logic                 probe_issued, probe_issued_next;

  logic [SW-1:0]        heads_ext;
  logic [CW-1:0]        n_sat;
  logic [TIME_BITS-1:0] occ_el, prb_el;
  logic                 solo_due, stable_due, limit_due;
  logic                 forbid;
  logic                 do_fail;
  logic                 wake, cancel, rel_media, start_probe;

  assign heads_ext = SW'(head_count);
  assign n_sat = (heads_ext > SW'(MAX_PARTICIPANTS)) ? CW'(MAX_PARTICIPANTS)
                                                      : CW'(heads_ext);

  assign occ_el = now_time - occ_stamp;
  assign prb_el = now_time - probe_stamp;
  assign solo_due   = CMPW'(occ_el) >= CMPW'(cfg.solo_sleep_delay);
  assign stable_due = CMPW'(occ_el) >= CMPW'(cfg.peer_stable_delay);
  assign limit_due  = CMPW'(prb_el) >= CMPW'(cfg.probe_time_limit);
  assign forbid = !cfg.peer_enable || cfg.server_denoise;

  always_comb begin
    life_next = life;
    route_next = route;
    count_next = count;
    occ_stamp_next = occ_stamp;
    probe_stamp_next = probe_stamp;
    probe_issued_next = probe_issued;
    wake = 1'b0;
    cancel = 1'b0;
    rel_media = 1'b0;
    start_probe = 1'b0;
    do_fail = 1'b0;

    unique case (cmd_t'(cmd))
      CMD_CONNECT: begin
        life_next = LIFE_ACTIVE;
        route_next = ROUTE_RELAY;
        count_next = '0;
        probe_issued_next = 1'b0;
        probe_stamp_next = '0;
        occ_stamp_next = now_time;
      end
      CMD_DISCONNECT: begin
        life_next = LIFE_OFF;
        route_next = ROUTE_RELAY;
        count_next = '0;
        probe_issued_next = 1'b0;
        probe_stamp_next = '0;
      end
      CMD_COUNT: begin
        if (n_sat != count) begin
          occ_stamp_next = now_time;
        end
        count_next = n_sat;
        if (life != LIFE_OFF) begin
          if (life == LIFE_SLEEP && n_sat >= CW'(2)) begin
            life_next = LIFE_ACTIVE;
            route_next = ROUTE_RELAY;
            probe_issued_next = 1'b0;
            probe_stamp_next = '0;
            occ_stamp_next = now_time;
            wake = 1'b1;
          end else if (n_sat != CW'(2) || forbid) begin
            cancel = (route != ROUTE_RELAY) || probe_issued;
            route_next = ROUTE_RELAY;
            probe_issued_next = 1'b0;
            probe_stamp_next = '0;
            occ_stamp_next = now_time;
          end
        end
      end
      CMD_TICK: begin
        if (life == LIFE_ACTIVE) begin
          if (count <= CW'(1) && solo_due) begin
            life_next = LIFE_SLEEP;
            route_next = ROUTE_RELAY;
            probe_issued_next = 1'b0;
            rel_media = 1'b1;
          end else if (count == CW'(2) && !forbid && route == ROUTE_RELAY &&
                       !probe_issued && stable_due) begin
            probe_issued_next = 1'b1;
            probe_stamp_next = now_time;
            route_next = ROUTE_PROBE;
            start_probe = 1'b1;
          end else if (route == ROUTE_PROBE && limit_due) begin
            do_fail = 1'b1;
          end
        end
      end
      CMD_PROBE_OK: begin
        if (life != LIFE_ACTIVE || count != CW'(2) || forbid) begin
          do_fail = 1'b1;
        end else begin
          route_next = ROUTE_PEER;
          probe_issued_next = 1'b0;
          probe_stamp_next = '0;
        end
      end
      CMD_PROBE_FAIL: begin
        do_fail = 1'b1;
      end
      CMD_APPLY: begin
        if (forbid) begin
          route_next = ROUTE_RELAY;
          probe_issued_next = 1'b0;
          probe_stamp_next = '0;
          occ_stamp_next = now_time;
        end
      end
      default: begin
      end
    endcase

    // probe failure: drop back to relay, cancel anything in flight
    if (do_fail) begin
      cancel = (route == ROUTE_PROBE) || probe_issued;
      route_next = ROUTE_RELAY;
      probe_issued_next = 1'b0;
      probe_stamp_next = '0;
      occ_stamp_next = now_time;
    end
  end

  assign res.life = life_next;
  assign res.route = route_next;
  assign res.wake = wake;
  assign res.cancel = cancel;
  assign res.rel_media = rel_media;
  assign res.start_probe = start_probe;

  always_ff @(posedge clk) begin
    if (rst) begin
      life <= LIFE_OFF;
      route <= ROUTE_RELAY;
      count <= '0;
      occ_stamp <= '0;
      probe_stamp <= '0;
      probe_issued <= 1'b0;
    end else if (step) begin
      life <= life_next;
      route <= route_next;
      count <= count_next;
      occ_stamp <= occ_stamp_next;
      probe_stamp <= probe_stamp_next;
      probe_issued <= probe_issued_next;
    end
  end

endmodule

// ===== design/voice_route_session_controller_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voice_route_session_controller_core
// Event-driven session lifecycle and media route controller.
// ----------------------------------------------------------------------------
// Takes one event word per cycle while in_stall is low and returns one result
// word per event, in order. An accepted event is held in an input register;
// its state update then runs through one pass of compare logic against the
// session registers and lands in the output register once that register is
// free or its result is taken. Throughput is one event per cycle unless the
// output is stalled. While a result is stalled the input register still takes
// one more event before in_stall rises. Time deltas are taken modulo
// 2^TIME_BITS; counts saturate at MAX_PARTICIPANTS. Write the configuration
// registers only while no events are in flight.
module voice_route_session_controller_core #(
  parameter int MAX_PARTICIPANTS = 255,
  parameter int TIME_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [vrsc_pkg::CMD_W-1:0]        cmd,
  input  logic [TIME_BITS-1:0]              now_time,
  input  logic [vrsc_pkg::HEADS_W-1:0]      head_count,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        life_state,
  output logic [1:0]                        route_state,
  output logic                              wake_request,
  output logic                              probe_cancel,
  output logic                              media_release,
  output logic                              probe_begin,
  input  logic                              cfg_write_en,
  input  logic [vrsc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [vrsc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import vrsc_pkg::*;

  cfg_t                 cfg;
  logic                 s1_valid;
  logic [CMD_W-1:0]     s1_cmd;
  logic [TIME_BITS-1:0] s1_time;
  logic [HEADS_W-1:0]   s1_heads;
  logic                 in_take;
  logic                 out_load;
  result_t              res_comb;
  result_t              res;

  assign out_load = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;
  assign in_take = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.peer_enable <= 1'b1;
      cfg.server_denoise <= 1'b0;
      cfg.solo_sleep_delay <= SOLO_SLEEP_RST;
      cfg.peer_stable_delay <= PEER_STABLE_RST;
      cfg.probe_time_limit <= PROBE_LIMIT_RST;
    end else if (cfg_write_en) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_PEER_ENABLE:    cfg.peer_enable <= cfg_data[0];
        CFG_SERVER_DENOISE: cfg.server_denoise <= cfg_data[0];
        CFG_SOLO_SLEEP:     cfg.solo_sleep_delay <= cfg_data[DELAY_W-1:0];
        CFG_PEER_STABLE:    cfg.peer_stable_delay <= cfg_data[DELAY_W-1:0];
        CFG_PROBE_LIMIT:    cfg.probe_time_limit <= cfg_data[DELAY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input word register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd <= cmd;
      s1_time <= now_time;
      s1_heads <= head_count;
    end
  end

  vrsc_engine #(
    .MAX_PARTICIPANTS(MAX_PARTICIPANTS),
    .TIME_BITS(TIME_BITS)
  ) u_engine (
    .clk(clk),
    .rst(rst),
    .step(out_load),
    .cmd(s1_cmd),
    .now_time(s1_time),
    .head_count(s1_heads),
    .cfg(cfg),
    .res(res_comb)
  );

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res <= res_comb;
    end
  end

  assign life_state = res.life;
  assign route_state = res.route;
  assign wake_request = res.wake;
  assign probe_cancel = res.cancel;
  assign media_release = res.rel_media;
  assign probe_begin = res.start_probe;

endmodule

// ===== design/vrsc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrsc_checker
// Port-level checks on the result words of the session controller.
// ----------------------------------------------------------------------------
module vrsc_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] life_state,
  input logic [1:0] route_state,
  input logic       wake_request,
  input logic       probe_cancel,
  input logic       media_release,
  input logic       probe_begin
);
  import vrsc_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid &&
      $stable({life_state, route_state, wake_request, probe_cancel,
               media_release, probe_begin}))
    else $error("result word changed while stalled");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({wake_request, probe_cancel, media_release, probe_begin}))
    else $error("more than one event flag in a result word");

  a_release_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && media_release |->
      life_state == LIFE_SLEEP && route_state == ROUTE_RELAY)
    else $error("media release without sleeping relay state");

  a_begin_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && probe_begin |->
      life_state == LIFE_ACTIVE && route_state == ROUTE_PROBE)
    else $error("probe begin without active probing state");

  a_wake_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && wake_request |->
      life_state == LIFE_ACTIVE && route_state == ROUTE_RELAY)
    else $error("wake request without active relay state");

endmodule

bind voice_route_session_controller_core vrsc_checker u_vrsc_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .life_state(life_state),
  .route_state(route_state),
  .wake_request(wake_request),
  .probe_cancel(probe_cancel),
  .media_release(media_release),
  .probe_begin(probe_begin)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for voice_route_session_controller_core.
// ----------------------------------------------------------------------------
// A queue of event words is filled by phase. Each phase may reprogram the
// session policy, but only once the block is idle. A clocked driver feeds
// the words with random idle bursts. The monitor runs a cycle-free model of
// the session on every accepted word and checks each result word in order
// while the receiver stalls in random bursts. Stimulus is a directed
// walk-through followed by random sessions and noise under several
// policies, the extreme delays among them.
// ----------------------------------------------------------------------------
module tb;
  import vrsc_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam logic [7:0] MAX_HEADS = 8'd255;

  typedef struct {
    logic [CMD_W-1:0]   op;
    logic [DELAY_W-1:0] stamp;
    logic [HEADS_W-1:0] heads;
  } event_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CMD_W-1:0] cmd = '0;
  logic [DELAY_W-1:0] now_time = '0;
  logic [HEADS_W-1:0] head_count = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] life_state;
  logic [1:0] route_state;
  logic wake_request;
  logic probe_cancel;
  logic media_release;
  logic probe_begin;
  logic cfg_write_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  event_word_t event_backlog[$];
  result_t session_results_due[$];
  event_word_t next_word;
  event_word_t seen_word;
  result_t want;
  int queued = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int gap_left = 0;
  int stall_left = 0;
  logic word_taken = 1'b0;
  logic [DELAY_W-1:0] stamp_cursor = '0;

  // session model state and its policy copy
  cfg_t policy = '{1'b1, 1'b0, SOLO_SLEEP_RST, PEER_STABLE_RST, PROBE_LIMIT_RST};
  life_t s_life = LIFE_OFF;
  route_t s_route = ROUTE_RELAY;
  logic [7:0] s_heads = '0;
  logic [DELAY_W-1:0] s_occ_stamp = '0;
  logic [DELAY_W-1:0] s_probe_stamp = '0;
  logic s_probe_issued = 1'b0;

  voice_route_session_controller_core i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .now_time(now_time),
    .head_count(head_count),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .life_state(life_state),
    .route_state(route_state),
    .wake_request(wake_request),
    .probe_cancel(probe_cancel),
    .media_release(media_release),
    .probe_begin(probe_begin),
    .cfg_write_en(cfg_write_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic void drop_probe(input logic [DELAY_W-1:0] t);
    s_probe_issued = 1'b0;
    s_probe_stamp = '0;
    s_occ_stamp = t;
  endfunction

  function automatic logic fail_probe(input logic [DELAY_W-1:0] t);
    logic was;
    was = (s_route == ROUTE_PROBE) || s_probe_issued;
    s_route = ROUTE_RELAY;
    drop_probe(t);
    return was;
  endfunction

  function automatic result_t next_session_result(input event_word_t w);
    result_t r;
    logic forbid;
    logic [7:0] n;
    logic [DELAY_W-1:0] since_occ;
    logic [DELAY_W-1:0] since_probe;
    r = '0;
    forbid = !policy.peer_enable || policy.server_denoise;
    since_occ = w.stamp - s_occ_stamp;
    since_probe = w.stamp - s_probe_stamp;
    case (w.op)
      CMD_CONNECT: begin
        s_life = LIFE_ACTIVE;
        s_route = ROUTE_RELAY;
        s_heads = '0;
        drop_probe(w.stamp);
      end
      CMD_DISCONNECT: begin
        s_life = LIFE_OFF;
        s_route = ROUTE_RELAY;
        s_heads = '0;
        s_probe_issued = 1'b0;
        s_probe_stamp = '0;
      end
      CMD_COUNT: begin
        n = (w.heads > MAX_HEADS) ? MAX_HEADS : w.heads;
        if (n != s_heads) s_occ_stamp = w.stamp;
        s_heads = n;
        if (s_life == LIFE_SLEEP && n >= 2) begin
          s_life = LIFE_ACTIVE;
          s_route = ROUTE_RELAY;
          drop_probe(w.stamp);
          r.wake = 1'b1;
        end else if (s_life != LIFE_OFF && (n != 2 || forbid)) begin
          r.cancel = (s_route != ROUTE_RELAY) || s_probe_issued;
          s_route = ROUTE_RELAY;
          drop_probe(w.stamp);
        end
      end
      CMD_TICK: begin
        if (s_life == LIFE_ACTIVE) begin
          if (s_heads <= 1 && since_occ >= policy.solo_sleep_delay) begin
            s_life = LIFE_SLEEP;
            s_route = ROUTE_RELAY;
            s_probe_issued = 1'b0;
            r.rel_media = 1'b1;
          end else if (s_heads == 2 && !forbid && s_route == ROUTE_RELAY &&
                       !s_probe_issued && since_occ >= policy.peer_stable_delay) begin
            s_probe_issued = 1'b1;
            s_probe_stamp = w.stamp;
            s_route = ROUTE_PROBE;
            r.start_probe = 1'b1;
          end else if (s_route == ROUTE_PROBE && since_probe >= policy.probe_time_limit) begin
            r.cancel = fail_probe(w.stamp);
          end
        end
      end
      CMD_PROBE_OK: begin
        if (s_life != LIFE_ACTIVE || s_heads != 2 || forbid) begin
          r.cancel = fail_probe(w.stamp);
        end else begin
          s_route = ROUTE_PEER;
          s_probe_issued = 1'b0;
          s_probe_stamp = '0;
        end
      end
      CMD_PROBE_FAIL: begin
        r.cancel = fail_probe(w.stamp);
      end
      CMD_APPLY: begin
        if (forbid) begin
          s_route = ROUTE_RELAY;
          drop_probe(w.stamp);
        end
      end
      default: begin
      end
    endcase
    r.life = s_life;
    r.route = s_route;
    return r;
  endfunction

  task automatic check_field(input string what, input logic [1:0] want_v,
                             input logic [1:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %0d got %0d", $time, what, want_v, got_v);
      mismatch_count++;
    end
  endtask

  // sender
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        gap_left <= $urandom_range(0, 7);
        in_valid <= 1'b0;
      end else if (event_backlog.size() != 0) begin
        next_word = event_backlog.pop_front();
        in_valid <= 1'b1;
        cmd <= next_word.op;
        now_time <= next_word.stamp;
        head_count <= next_word.heads;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      word_taken <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      word_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        seen_word.op = cmd;
        seen_word.stamp = now_time;
        seen_word.heads = head_count;
        session_results_due.push_back(next_session_result(seen_word));
      end
      if (out_valid && !out_stall) begin
        if (session_results_due.size() == 0) begin
          $display("%0t: result word with none expected", $time);
          mismatch_count++;
        end else begin
          want = session_results_due.pop_front();
          check_field("life_state", want.life, life_state);
          check_field("route_state", want.route, route_state);
          check_field("wake_request", {1'b0, want.wake}, {1'b0, wake_request});
          check_field("probe_cancel", {1'b0, want.cancel}, {1'b0, probe_cancel});
          check_field("media_release", {1'b0, want.rel_media}, {1'b0, media_release});
          check_field("probe_begin", {1'b0, want.start_probe}, {1'b0, probe_begin});
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("voice_route_session_controller_core test failed");
    $finish;
  end

  function automatic logic [DELAY_W-1:0] pick_step();
    case ($urandom_range(0, 11))
      0: return '0;
      1, 2, 3, 4: return $urandom_range(1, 40);
      5: return policy.solo_sleep_delay;
      6: return policy.peer_stable_delay;
      7: return policy.probe_time_limit;
      8: return policy.peer_stable_delay - 1;
      9: return $urandom;
      default: return $urandom_range(0, 3000);
    endcase
  endfunction

  function automatic logic [7:0] pick_heads();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1, 2: return 8'd1;
      3, 4, 5: return 8'd2;
      6: return 8'd3;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_at(input logic [CMD_W-1:0] op, input logic [DELAY_W-1:0] t,
                        input logic [7:0] heads);
    event_word_t w;
    w.op = op;
    w.stamp = t;
    w.heads = heads;
    stamp_cursor = t;
    event_backlog.push_back(w);
    queued++;
  endtask

  task automatic add_event(input logic [CMD_W-1:0] op, input logic [7:0] heads);
    add_at(op, stamp_cursor + pick_step(), heads);
  endtask

  task automatic add_session();
    add_event(CMD_CONNECT, 8'($urandom_range(0, 255)));
    add_event(CMD_COUNT, pick_heads());
    repeat ($urandom_range(2, 12)) begin
      case ($urandom_range(0, 11))
        0: add_event(CMD_PROBE_OK, 8'($urandom_range(0, 255)));
        1: add_event(CMD_PROBE_FAIL, 8'($urandom_range(0, 255)));
        2, 3: add_event(CMD_COUNT, pick_heads());
        4: add_event(CMD_APPLY, 8'($urandom_range(0, 255)));
        default: add_event(CMD_TICK, 8'($urandom_range(0, 255)));
      endcase
    end
    if ($urandom_range(0, 2) == 0) add_event(CMD_DISCONNECT, 8'($urandom_range(0, 255)));
  endtask

  task automatic fill_random(input int n);
    int goal;
    goal = queued + n;
    while (queued < goal) begin
      if ($urandom_range(0, 4) == 0)
        add_event(CMD_W'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
      else add_session();
    end
  endtask

  // leaves the session on a peer route, where the policy allows one, so the next policy change has work to do
  task automatic reach_peer();
    add_event(CMD_CONNECT, 8'd0);
    add_event(CMD_COUNT, 8'd2);
    add_event(CMD_PROBE_OK, 8'd0);
  endtask

  task automatic settle();
    while (event_backlog.size() != 0 || in_valid || session_results_due.size() != 0)
      @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_PEER_ENABLE: policy.peer_enable = val[0];
      CFG_SERVER_DENOISE: policy.server_denoise = val[0];
      CFG_SOLO_SLEEP: policy.solo_sleep_delay = val;
      CFG_PEER_STABLE: policy.peer_stable_delay = val;
      CFG_PROBE_LIMIT: policy.probe_time_limit = val;
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic run_phase(input logic pe, input logic sd, input logic [31:0] solo,
                           input logic [31:0] stable, input logic [31:0] limit,
                           input int n, input logic calm);
    settle();
    write_reg(CFG_PEER_ENABLE, {31'd0, pe});
    write_reg(CFG_SERVER_DENOISE, {31'd0, sd});
    write_reg(CFG_SOLO_SLEEP, solo);
    write_reg(CFG_PEER_STABLE, stable);
    write_reg(CFG_PROBE_LIMIT, limit);
    idle_pct = calm ? 0 : 10 * $urandom_range(0, 3);
    stall_pct = calm ? 0 : 10 * $urandom_range(0, 3);
    add_event(CMD_APPLY, 8'($urandom_range(0, 255)));
    fill_random(n);
    reach_peer();
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    idle_pct = 20;
    stall_pct = 20;
    add_at(CMD_TICK, 32'd0, 8'd0);
    add_at(3'd7, 32'd10, 8'hAA);
    add_at(CMD_PROBE_OK, 32'd20, 8'd2);
    add_at(CMD_COUNT, 32'd30, 8'd255);
    add_at(CMD_CONNECT, 32'd100, 8'd0);
    add_at(CMD_COUNT, 32'd100, 8'd2);
    add_at(CMD_TICK, 32'd2099, 8'd0);
    add_at(CMD_TICK, 32'd2100, 8'd0);
    add_at(CMD_COUNT, 32'd2200, 8'd3);
    add_at(CMD_COUNT, 32'd2300, 8'd2);
    add_at(CMD_TICK, 32'd4300, 8'd0);
    add_at(CMD_TICK, 32'd9300, 8'd0);
    add_at(CMD_TICK, 32'd11300, 8'd0);
    add_at(CMD_PROBE_OK, 32'd11400, 8'd0);
    add_at(CMD_APPLY, 32'd11500, 8'd0);
    add_at(CMD_COUNT, 32'd11600, 8'd1);
    add_at(CMD_TICK, 32'd41600, 8'd0);
    add_at(CMD_COUNT, 32'd41700, 8'd0);
    add_at(CMD_COUNT, 32'd41800, 8'd2);
    add_at(CMD_PROBE_FAIL, 32'd41900, 8'd0);
    add_at(CMD_PROBE_OK, 32'd41950, 8'd0);
    add_at(CMD_DISCONNECT, 32'd42000, 8'hFF);
    add_at(CMD_CONNECT, 32'hFFFF_FF00, 8'd0);
    add_at(CMD_COUNT, 32'hFFFF_FF00, 8'd2);
    add_at(CMD_TICK, 32'h0000_06D0, 8'd0);
    fill_random(250);
    reach_peer();

    run_phase(1'b0, 1'b0, 32'd40, 32'd20, 32'd30, 200, 1'b0);
    run_phase(1'b1, 1'b1, 32'd40, 32'd20, 32'd30, 200, 1'b0);
    run_phase(1'b1, 1'b0, 32'd0, 32'd0, 32'd0, 250, 1'b0);
    run_phase(1'b1, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 200, 1'b0);
    run_phase(1'b1, 1'b0, $urandom_range(1, 60), $urandom_range(1, 60),
              $urandom_range(1, 60), 400, 1'b0);
    run_phase($urandom_range(0, 3) != 0, $urandom_range(0, 3) == 0,
              $urandom_range(0, 100), $urandom_range(0, 100), $urandom_range(0, 100),
              250, 1'b1);

    settle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("voice_route_session_controller_core test passed");
    end else begin
      $display("voice_route_session_controller_core test failed");
    end
    $finish;
  end

endmodule
